// ===== sv/bcsm_pkg.sv =====
// Package with the shared types and constants of the battery charge state machine.
package bcsm_pkg;

    // Charge mode codes.
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_PRE  = 2'd1,
        MODE_CHG  = 2'd2,
        MODE_DIS  = 2'd3
    } t_mode;

    // Wait period codes.
    typedef enum logic [1:0] {
        WAIT_NONE = 2'd0,
        WAIT_T1   = 2'd1,
        WAIT_T2   = 2'd2,
        WAIT_T3   = 2'd3
    } t_wait;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIS_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_SOC    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_INT = 3'd5;

    // Register reset values.
    localparam logic signed [8:0] RST_START_MIN  = 9'sd5;
    localparam logic signed [8:0] RST_START_MAX  = 9'sd40;
    localparam logic signed [8:0] RST_CHARGE_MAX = 9'sd60;
    localparam logic signed [8:0] RST_DIS_MAX    = 9'sd70;
    localparam logic [6:0]        RST_LOW_SOC    = 7'd10;
    localparam logic [31:0]       RST_NOTIFY_INT = 32'd60000;

    // Interrupt event bits.
    localparam int EV_AC_GOOD_BIT  = 1;
    localparam int EV_BAT_GOOD_BIT = 3;

    // Smart battery alarm masks.
    localparam logic [15:0] AL_CHG_MASK = 16'hD000;
    localparam logic [15:0] AL_DIS_MASK = 16'h1800;

    // Charger status fault flags.
    localparam logic [7:0] CS_FAULT_MASK = 8'h03;

    // Deci-kelvin offset and divide-by-ten reciprocal (exact for 16-bit values).
    localparam logic signed [16:0] KELVIN_OFFSET_DK = 17'sd2731;
    localparam logic [15:0]        DIV10_RECIP      = 16'd52429;
    localparam int                 DIV10_SHIFT      = 19;

endpackage

// ===== sv/battery_charge_state_machine.sv =====
// Battery charge state machine: one charge decision per poll snapshot item.
//
//  Channel  | Direction | Handshake                      | Payload
//  ---------+-----------+--------------------------------+-------------------------------
//  poll in  | input     | i_in_valid / o_in_ready        | read errors, readings, i_now_ms
//  decision | output    | o_out_valid / i_out_ready      | mode, charger, off, notice, wait
//  config   | input     | i_cfg_wr_en (no wait)          | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the result is taken; an item waits in the input
// register and then leaves through the result register.
// The decision logic (divide by ten through one 16x16 multiply, compares, the mode
// update) sits between the two registers and reads the mode held for the prior item.
// Reset is synchronous, active low; it returns the mode to idle, clears the charger
// enable, the notice time and both valid bits, and loads the register defaults.
// A stalled result holds the input register; a new item is still taken whenever
// the input register empties into the result register in the same cycle.
module battery_charge_state_machine
    import bcsm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration port
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    // Poll input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_irq_read_error,
    input  logic [15:0]          i_irq_event,
    input  logic                 i_batt_status_error,
    input  logic [15:0]          i_batt_alarm_word,
    input  logic                 i_temp_error,
    input  logic [15:0]          i_temp_decikelvin,
    input  logic                 i_chg_status_error,
    input  logic [7:0]           i_chg_status,
    input  logic                 i_soc_error,
    input  logic [6:0]           i_soc_percent,
    input  logic [31:0]          i_now_ms,
    // Decision output channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_next_mode,
    output logic                 o_charger_on,
    output logic                 o_power_off,
    output logic                 o_battery_low_notice,
    output logic [1:0]           o_wait_select
);

    // Configuration registers
    logic signed [8:0] r_start_min;
    logic signed [8:0] r_start_max;
    logic signed [8:0] r_charge_max;
    logic signed [8:0] r_dis_max;
    logic [6:0]        r_low_soc;
    logic [31:0]       r_notify_int;

    // Input register
    logic        r_s1_valid;
    logic        r_irq_err;
    logic [15:0] r_irq_event;
    logic        r_bst_err;
    logic [15:0] r_alarm;
    logic        r_temp_err;
    logic [15:0] r_temp_dk;
    logic        r_cs_err;
    logic [7:0]  r_cs;
    logic        r_soc_err;
    logic [6:0]  r_soc;
    logic [31:0] r_now;

    // Block state
    t_mode       r_mode;
    t_mode       n_mode;
    logic        r_chg_en;
    logic        n_chg_en;
    logic [31:0] r_last_notice;
    logic [31:0] n_last_notice;

    // Result register
    logic        r_out_valid;
    t_mode       r_out_mode;
    logic        r_out_chg_en;
    logic        r_out_off;
    logic        r_out_notice;
    t_wait       r_out_wait;

    // Decision signals
    logic               s1_move;
    logic               ac;
    logic signed [16:0] t_diff;
    logic               t_neg;
    logic [15:0]        t_mag;
    logic [31:0]        t_prod;
    logic [12:0]        t_quot;
    logic signed [13:0] tc;
    logic               temp_start_ok;
    logic               temp_charge_ok;
    logic               temp_dis_hot;
    logic               chg_alarm;
    logic               dis_alarm;
    logic               cs_fault;
    logic               soc_low;
    logic               notice_due;
    logic               n_off;
    logic               n_notice;
    t_wait              n_wait;

    // Handshake: the input register empties whenever the result register can take it.
    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_min  <= RST_START_MIN;
            r_start_max  <= RST_START_MAX;
            r_charge_max <= RST_CHARGE_MAX;
            r_dis_max    <= RST_DIS_MAX;
            r_low_soc    <= RST_LOW_SOC;
            r_notify_int <= RST_NOTIFY_INT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_START_MIN:  r_start_min  <= $signed(i_cfg_data[8:0]);
                CFG_START_MAX:  r_start_max  <= $signed(i_cfg_data[8:0]);
                CFG_CHARGE_MAX: r_charge_max <= $signed(i_cfg_data[8:0]);
                CFG_DIS_MAX:    r_dis_max    <= $signed(i_cfg_data[8:0]);
                CFG_LOW_SOC:    r_low_soc    <= i_cfg_data[6:0];
                CFG_NOTIFY_INT: r_notify_int <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_irq_err   <= i_irq_read_error;
            r_irq_event <= i_irq_event;
            r_bst_err   <= i_batt_status_error;
            r_alarm     <= i_batt_alarm_word;
            r_temp_err  <= i_temp_error;
            r_temp_dk   <= i_temp_decikelvin;
            r_cs_err    <= i_chg_status_error;
            r_cs        <= i_chg_status;
            r_soc_err   <= i_soc_error;
            r_soc       <= i_soc_percent;
            r_now       <= i_now_ms;
        end
    end

    // Celsius conversion, truncating toward zero: divide the magnitude, then restore sign.
    always_comb begin
        t_diff = $signed({1'b0, r_temp_dk}) - KELVIN_OFFSET_DK;
        t_neg  = t_diff[16];
        t_mag  = t_neg ? 16'(-t_diff) : t_diff[15:0];
        t_prod = t_mag * DIV10_RECIP;
        t_quot = t_prod[DIV10_SHIFT+12:DIV10_SHIFT];
        tc     = t_neg ? -$signed({1'b0, t_quot}) : $signed({1'b0, t_quot});
    end

    // Condition terms shared by the mode arms
    always_comb begin
        if (r_irq_err) begin
            ac = 1'b0;
        end else if (r_irq_event[EV_AC_GOOD_BIT] && r_irq_event[EV_BAT_GOOD_BIT]) begin
            ac = 1'b1;
        end else begin
            ac = r_bst_err;
        end
        temp_start_ok  = (tc > 14'(r_start_min)) && (tc < 14'(r_start_max));
        temp_charge_ok = (tc > 14'(r_start_min)) && (tc < 14'(r_charge_max));
        temp_dis_hot   = !(tc < 14'(r_dis_max));
        chg_alarm      = |(r_alarm & AL_CHG_MASK);
        dis_alarm      = |(r_alarm & AL_DIS_MASK);
        cs_fault       = |(r_cs & CS_FAULT_MASK);
        soc_low        = !r_soc_err && (r_soc < r_low_soc);
        notice_due     = (r_now - r_last_notice) > r_notify_int;
    end

    // Next mode, charger level and result flags
    always_comb begin
        n_mode        = MODE_IDLE;
        n_chg_en      = r_chg_en;
        n_last_notice = r_last_notice;
        n_off         = 1'b0;
        n_notice      = 1'b0;
        n_wait        = WAIT_NONE;
        unique case (r_mode)
            MODE_IDLE: begin
                n_chg_en = 1'b0;
                priority if (!ac) begin
                    n_mode = MODE_DIS;
                end else if (r_temp_err) begin
                    n_mode = MODE_PRE;
                end else if (!temp_start_ok || r_bst_err || chg_alarm) begin
                    n_wait = WAIT_T1;
                end else begin
                    n_chg_en = 1'b1;
                    n_mode   = MODE_CHG;
                end
            end
            MODE_PRE: begin
                if (!ac) begin
                    n_wait = WAIT_T1;
                end else begin
                    n_chg_en = 1'b1;
                    if (!r_temp_err) begin
                        n_mode = MODE_CHG;
                    end else begin
                        n_mode = MODE_PRE;
                        n_wait = WAIT_T1;
                    end
                end
            end
            MODE_CHG: begin
                if (ac && !r_temp_err && temp_charge_ok && !r_bst_err && !chg_alarm
                        && !r_cs_err && !cs_fault) begin
                    n_mode = MODE_CHG;
                    n_wait = WAIT_T2;
                end
            end
            MODE_DIS: begin
                priority if (ac) begin
                    n_mode = MODE_IDLE;
                end else if ((!r_temp_err && temp_dis_hot) || r_bst_err || dis_alarm) begin
                    n_off = 1'b1;
                end else if (soc_low) begin
                    n_mode = MODE_DIS;
                    if (notice_due) begin
                        n_notice      = 1'b1;
                        n_last_notice = r_now;
                    end
                end else begin
                    n_mode = MODE_DIS;
                    n_wait = WAIT_T3;
                end
            end
            default: ;
        endcase
    end

    // State register: advances once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_chg_en      <= 1'b0;
            r_last_notice <= '0;
        end else if (s1_move) begin
            r_mode        <= n_mode;
            r_chg_en      <= n_chg_en;
            r_last_notice <= n_last_notice;
        end
    end

    // Result register valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_mode   <= n_mode;
            r_out_chg_en <= n_chg_en;
            r_out_off    <= n_off;
            r_out_notice <= n_notice;
            r_out_wait   <= n_wait;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_next_mode          = r_out_mode;
    assign o_charger_on         = r_out_chg_en;
    assign o_power_off          = r_out_off;
    assign o_battery_low_notice = r_out_notice;
    assign o_wait_select        = r_out_wait;

    // The mode only changes when an item passes through the decision logic.
    a_mode_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_move |=> $stable(r_mode))
        else $error("charge mode changed without an item");

    // Charging is only ever reached with the charger enabled.
    a_chg_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_next_mode == MODE_CHG) |-> o_charger_on)
        else $error("charging result without charger enable");

    // A power-off request always returns the mode to idle.
    a_off_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_power_off |-> (o_next_mode == MODE_IDLE) && !o_battery_low_notice)
        else $error("system off with a mode other than idle");

    // A low-battery notice only comes while discharging, with no wait.
    a_notice_dis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_battery_low_notice |->
            (o_next_mode == MODE_DIS) && (o_wait_select == WAIT_NONE))
        else $error("notice outside discharging");

    // A notice records the item time as the last notice time.
    a_notice_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && n_notice |=> r_last_notice == $past(r_now))
        else $error("notice time not recorded");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the battery charge state machine: directed rows, then random polls.
`timescale 1ns / 1ps

module tb_top;
    import bcsm_pkg::*;

    localparam int ITEMS_PER_PHASE = 238;
    localparam int N_PHASES        = 6;
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_WAIT_LIMIT  = 5000;
    localparam int TIMEOUT_NS      = 5_000_000;
    localparam int DK_OFFSET       = 2731;

    // Alarm and status bits as the charge decision reads them.
    localparam logic [15:0] ALARM_CHARGE_STOP = 16'h8000 | 16'h4000 | 16'h1000;
    localparam logic [15:0] ALARM_DISCH_STOP  = 16'h0800 | 16'h1000;
    localparam logic [7:0]  CHG_FAULT_BITS    = 8'h03;

    // One poll snapshot.
    typedef struct {
        logic        irq_err;
        logic [15:0] irq_ev;
        logic        bst_err;
        logic [15:0] alarm;
        logic        t_err;
        logic [15:0] temp_dk;
        logic        cs_err;
        logic [7:0]  cs;
        logic        soc_err;
        logic [6:0]  soc;
        logic [31:0] now_ms;
    } t_poll;

    // One charge decision.
    typedef struct {
        t_mode mode;
        logic  chg_on;
        logic  sys_off;
        logic  low_notice;
        t_wait wt;
    } t_decision;

    typedef struct {
        t_poll     poll;
        logic      typed;
        t_decision want;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_irq_read_error;
    logic [15:0]          i_irq_event;
    logic                 i_batt_status_error;
    logic [15:0]          i_batt_alarm_word;
    logic                 i_temp_error;
    logic [15:0]          i_temp_decikelvin;
    logic                 i_chg_status_error;
    logic [7:0]           i_chg_status;
    logic                 i_soc_error;
    logic [6:0]           i_soc_percent;
    logic [31:0]          i_now_ms;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [1:0]           o_next_mode;
    logic                 o_charger_on;
    logic                 o_power_off;
    logic                 o_battery_low_notice;
    logic [1:0]           o_wait_select;

    // Predictor copy of the block state and its registers.
    t_mode       mode_q;
    logic        chg_en_q;
    logic [31:0] last_notice_q;
    int          cfg_start_min;
    int          cfg_start_max;
    int          cfg_charge_max;
    int          cfg_disch_max;
    logic [6:0]  cfg_low_soc;
    logic [31:0] cfg_notify_ms;

    t_decision   pending_decisions[$];
    int          err_cnt;
    int          send_idle_pct;
    int          stall_pct;
    logic [31:0] clock_ms;

    battery_charge_state_machine u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_irq_read_error     (i_irq_read_error),
        .i_irq_event          (i_irq_event),
        .i_batt_status_error  (i_batt_status_error),
        .i_batt_alarm_word    (i_batt_alarm_word),
        .i_temp_error         (i_temp_error),
        .i_temp_decikelvin    (i_temp_decikelvin),
        .i_chg_status_error   (i_chg_status_error),
        .i_chg_status         (i_chg_status),
        .i_soc_error          (i_soc_error),
        .i_soc_percent        (i_soc_percent),
        .i_now_ms             (i_now_ms),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_next_mode          (o_next_mode),
        .o_charger_on         (o_charger_on),
        .o_power_off          (o_power_off),
        .o_battery_low_notice (o_battery_low_notice),
        .o_wait_select        (o_wait_select)
    );

    // 100 MHz clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // Receiver side: random back-pressure, changed on the falling edge.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: ERROR %s", $time, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    // Charge decision for one poll; advances the predictor state.
    task automatic predict_decision(input t_poll p, output t_decision d);
        logic        ac;
        int          tc;
        t_mode       nxt;
        logic        off;
        logic        notice;
        t_wait       wt;
        logic [31:0] since;
        tc     = (int'(p.temp_dk) - DK_OFFSET) / 10;
        nxt    = MODE_IDLE;
        off    = 1'b0;
        notice = 1'b0;
        wt     = WAIT_NONE;
        // Without a read error, AC is reported when both event bits are set or the battery is silent.
        if (p.irq_err) begin
            ac = 1'b0;
        end else if (p.irq_ev[EV_AC_GOOD_BIT] && p.irq_ev[EV_BAT_GOOD_BIT]) begin
            ac = 1'b1;
        end else begin
            ac = p.bst_err;
        end
        case (mode_q)
            MODE_IDLE: begin
                chg_en_q = 1'b0;
                if (!ac) begin
                    nxt = MODE_DIS;
                end else if (p.t_err) begin
                    nxt = MODE_PRE;
                end else if (!(tc > cfg_start_min && tc < cfg_start_max)) begin
                    wt = WAIT_T1;
                end else if (p.bst_err || (p.alarm & ALARM_CHARGE_STOP) != 0) begin
                    wt = WAIT_T1;
                end else begin
                    chg_en_q = 1'b1;
                    nxt      = MODE_CHG;
                end
            end
            MODE_PRE: begin
                if (!ac) begin
                    wt = WAIT_T1;
                end else begin
                    chg_en_q = 1'b1;
                    if (!p.t_err) begin
                        nxt = MODE_CHG;
                    end else begin
                        nxt = MODE_PRE;
                        wt  = WAIT_T1;
                    end
                end
            end
            MODE_CHG: begin
                if (!ac || p.t_err || !(tc > cfg_start_min && tc < cfg_charge_max) ||
                    p.bst_err || (p.alarm & ALARM_CHARGE_STOP) != 0 || p.cs_err ||
                    (p.cs & CHG_FAULT_BITS) != 0) begin
                    nxt = MODE_IDLE;
                end else begin
                    nxt = MODE_CHG;
                    wt  = WAIT_T2;
                end
            end
            default: begin
                if (ac) begin
                    nxt = MODE_IDLE;
                end else if (!p.t_err && !(tc < cfg_disch_max)) begin
                    off = 1'b1;
                end else if (p.bst_err || (p.alarm & ALARM_DISCH_STOP) != 0) begin
                    off = 1'b1;
                end else if (!p.soc_err && p.soc < cfg_low_soc) begin
                    // Low battery: notice at most once per interval.
                    since = p.now_ms - last_notice_q;
                    if (since > cfg_notify_ms) begin
                        notice        = 1'b1;
                        last_notice_q = p.now_ms;
                    end
                    nxt = MODE_DIS;
                end else begin
                    nxt = MODE_DIS;
                    wt  = WAIT_T3;
                end
            end
        endcase
        mode_q = nxt;
        d = '{nxt, chg_en_q, off, notice, wt};
    endtask

    function automatic t_poll poll_of(input int irq_err, input int ev, input int bst,
                                      input int alarm, input int terr, input int dk,
                                      input int cserr, input int cs, input int socerr,
                                      input int soc, input logic [31:0] now);
        t_poll p;
        p = '{irq_err[0], ev[15:0], bst[0], alarm[15:0], terr[0], dk[15:0],
              cserr[0], cs[7:0], socerr[0], soc[6:0], now};
        return p;
    endfunction

    // Register write on the falling edge; the enable is lowered by the caller.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_START_MIN:  cfg_start_min  = $signed(data[8:0]);
            CFG_START_MAX:  cfg_start_max  = $signed(data[8:0]);
            CFG_CHARGE_MAX: cfg_charge_max = $signed(data[8:0]);
            CFG_DIS_MAX:    cfg_disch_max  = $signed(data[8:0]);
            CFG_LOW_SOC:    cfg_low_soc    = data[6:0];
            CFG_NOTIFY_INT: cfg_notify_ms  = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // All six registers; unused upper data bits carry random junk.
    task automatic set_config(input int smin, input int smax, input int cmax, input int dmax,
                              input int low, input logic [31:0] intv);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_START_MIN, {junk[31:9], 9'(smin)});
        write_reg(CFG_START_MAX, {junk[30:8], 9'(smax)});
        write_reg(CFG_CHARGE_MAX, {junk[29:7], 9'(cmax)});
        write_reg(CFG_DIS_MAX, {junk[28:6], 9'(dmax)});
        write_reg(CFG_LOW_SOC, {junk[31:7], 7'(low)});
        write_reg(CFG_NOTIFY_INT, intv);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Stop sending until every expected decision has come back.
    task automatic drain_decisions();
        i_in_valid <= 1'b0;
        while (pending_decisions.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Present one item on the falling edge and hold it until it is taken.
    task automatic send_poll(input t_poll p, input logic typed, input t_decision want);
        t_decision d;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_irq_read_error    <= p.irq_err;
        i_irq_event         <= p.irq_ev;
        i_batt_status_error <= p.bst_err;
        i_batt_alarm_word   <= p.alarm;
        i_temp_error        <= p.t_err;
        i_temp_decikelvin   <= p.temp_dk;
        i_chg_status_error  <= p.cs_err;
        i_chg_status        <= p.cs;
        i_soc_error         <= p.soc_err;
        i_soc_percent       <= p.soc;
        i_now_ms            <= p.now_ms;
        i_in_valid          <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_decision(p, d);
        if (typed) begin
            d = want;
        end
        pending_decisions.push_back(d);
        @(negedge i_clk);
    endtask

    // Random poll biased toward the thresholds and the notice boundary.
    task automatic gen_poll(output t_poll p);
        int thr;
        int dk;
        int s;
        p.irq_err = ($urandom_range(0, 11) == 0);
        p.irq_ev  = 16'($urandom);
        if ($urandom_range(0, 1) == 1) begin
            p.irq_ev[EV_AC_GOOD_BIT]  = 1'b1;
            p.irq_ev[EV_BAT_GOOD_BIT] = 1'b1;
        end
        p.bst_err = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: p.alarm = 16'h0000;
            6, 7:             p.alarm = 16'h0001 << $urandom_range(0, 15);
            default:          p.alarm = 16'($urandom);
        endcase
        p.t_err = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 3))
            0:       thr = cfg_start_min;
            1:       thr = cfg_start_max;
            2:       thr = cfg_charge_max;
            default: thr = cfg_disch_max;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: dk = thr * 10 + DK_OFFSET + int'($urandom_range(0, 40)) - 20;
            5, 6, 7: dk = (int'($urandom_range(0, 190)) - 40) * 10 + DK_OFFSET +
                          int'($urandom_range(0, 9));
            default: dk = int'($urandom_range(0, 65535));
        endcase
        if (dk < 0) dk = 0;
        if (dk > 65535) dk = 65535;
        p.temp_dk = dk[15:0];
        p.cs_err  = ($urandom_range(0, 9) == 0);
        p.cs      = 8'($urandom);
        if ($urandom_range(0, 9) < 7) begin
            p.cs[1:0] = 2'b00;
        end
        p.soc_err = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 4))
            0: begin
                s = int'(cfg_low_soc) - 1 + int'($urandom_range(0, 2));
                if (s < 0) s = 0;
                if (s > 127) s = 127;
                p.soc = s[6:0];
            end
            1:       p.soc = 7'($urandom_range(0, 127));
            default: p.soc = 7'($urandom_range(0, 100));
        endcase
        // Time mostly moves forward; sometimes lands right on the notice interval.
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: clock_ms = clock_ms + $urandom_range(0, 3000);
            6, 7: clock_ms = last_notice_q + cfg_notify_ms - 32'd1 + $urandom_range(0, 2);
            8:    clock_ms = clock_ms + cfg_notify_ms;
            default: clock_ms = $urandom;
        endcase
        p.now_ms = clock_ms;
    endtask

    // Decision channel: compare each result with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_decision w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_decisions.size() == 0) begin
                report_mismatch("decision item with no expectation waiting");
            end else begin
                w = pending_decisions.pop_front();
                check_field("next_mode", o_next_mode, w.mode);
                check_field("charger_on", o_charger_on, w.chg_on);
                check_field("power_off", o_power_off, w.sys_off);
                check_field("battery_low_notice", o_battery_low_notice, w.low_notice);
                check_field("wait_select", o_wait_select, w.wt);
            end
        end
    end

    initial begin
        t_row      dir_rows[$];
        t_poll     p;
        t_decision no_want;
        int        smin;
        int        wait_cycles;

        // Known values on every input from time zero.
        i_rst_n             = 1'b0;
        i_cfg_wr_en         = 1'b0;
        i_cfg_index         = CFG_START_MIN;
        i_cfg_data          = 32'd0;
        i_in_valid          = 1'b0;
        i_out_ready         = 1'b0;
        i_irq_read_error    = 1'b0;
        i_irq_event         = 16'd0;
        i_batt_status_error = 1'b0;
        i_batt_alarm_word   = 16'd0;
        i_temp_error        = 1'b0;
        i_temp_decikelvin   = 16'd0;
        i_chg_status_error  = 1'b0;
        i_chg_status        = 8'd0;
        i_soc_error         = 1'b0;
        i_soc_percent       = 7'd0;
        i_now_ms            = 32'd0;
        err_cnt             = 0;
        send_idle_pct       = 0;
        stall_pct           = 30;
        clock_ms            = 32'd0;

        // State and registers as they come out of reset.
        mode_q         = MODE_IDLE;
        chg_en_q       = 1'b0;
        last_notice_q  = 32'd0;
        cfg_start_min  = 5;
        cfg_start_max  = 40;
        cfg_charge_max = 60;
        cfg_disch_max  = 70;
        cfg_low_soc    = 7'd10;
        cfg_notify_ms  = 32'd60000;
        no_want        = '{MODE_IDLE, 1'b0, 1'b0, 1'b0, WAIT_NONE};

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed walk through every mode. Arguments: irq_err, event, batt_err, alarm,
        // temp_err, deci-kelvin, chg_err, chg_status, soc_err, soc, now.
        // Read error on the interrupts means no AC: idle goes to discharging.
        dir_rows.push_back('{poll_of(1, 'hFFFF, 0, 0, 0, 2981, 0, 0, 0, 50, 0), 1'b1,
                             '{MODE_DIS, 1'b0, 1'b0, 1'b0, WAIT_NONE}});
        // Both event bits: AC back, return to idle.
        dir_rows.push_back('{poll_of(0, 'h000A, 0, 0, 0, 2981, 0, 0, 0, 50, 0), 1'b1,
                             '{MODE_IDLE, 1'b0, 1'b0, 1'b0, WAIT_NONE}});
        // Temperature read fails with AC: pre-charging.
        dir_rows.push_back('{poll_of(0, 'h000A, 0, 0, 1, 'hFFFF, 0, 0, 0, 50, 0), 1'b1,
                             '{MODE_PRE, 1'b0, 1'b0, 1'b0, WAIT_NONE}});
        // Silent battery counts as AC; still no temperature.
        dir_rows.push_back('{poll_of(0, 0, 1, 0, 1, 'hFFFF, 0, 0, 0, 50, 0), 1'b1,
                             '{MODE_PRE, 1'b1, 1'b0, 1'b0, WAIT_T1}});
        dir_rows.push_back('{poll_of(0, 'h000A, 0, 0, 0, 0, 0, 0, 0, 50, 0), 1'b1,
                             '{MODE_CHG, 1'b1, 1'b0, 1'b0, WAIT_NONE}});
        // Charging: healthy, then a charger fault flag.
        dir_rows.push_back('{poll_of(0, 'hFFFF, 0, 0, 0, 2981, 0, 'hFC, 0, 50, 0), 1'b0, no_want});
        dir_rows.push_back('{poll_of(0, 'hFFFF, 0, 0, 0, 2981, 0, 'h02, 0, 50, 0), 1'b0, no_want});
        // Idle with temperature extremes and charge alarms; an alarm word with no charge bit starts charging.
        dir_rows.push_back('{poll_of(0, 'h000A, 0, 0, 0, 0, 0, 0, 0, 50, 0), 1'b0, no_want});
        dir_rows.push_back('{poll_of(0, 'h000A, 0, 0, 0, 'hFFFF, 0, 0, 0, 50, 0), 1'b0, no_want});
        dir_rows.push_back('{poll_of(0, 'h000A, 0, 'h1000, 0, 2981, 0, 0, 0, 50, 0), 1'b0,
                             no_want});
        dir_rows.push_back('{poll_of(0, 'h000A, 0, 'h2FFF, 0, 2981, 0, 0, 0, 50, 0), 1'b0,
                             no_want});
        dir_rows.push_back('{poll_of(0, 'h000A, 0, 'h8000, 0, 2981, 0, 0, 0, 50, 0), 1'b0,
                             no_want});
        // Start window edges: 5 C refused, 6 C starts; 60 C stops charging.
        dir_rows.push_back('{poll_of(0, 'h000A, 0, 0, 0, 2781, 0, 0, 0, 50, 0), 1'b0, no_want});
        dir_rows.push_back('{poll_of(0, 'h000A, 0, 0, 0, 2791, 0, 0, 0, 50, 0), 1'b0, no_want});
        dir_rows.push_back('{poll_of(0, 'h000A, 0, 0, 0, 3331, 0, 0, 0, 50, 0), 1'b0, no_want});
        dir_rows.push_back('{poll_of(0, 'h000A, 0, 0, 0, 3121, 0, 0, 0, 50, 0), 1'b0, no_want});
        dir_rows.push_back('{poll_of(0, 'h000A, 0, 0, 0, 3121, 1, 0, 0, 50, 0), 1'b0, no_want});
        // Discharging: over temperature, then a discharge alarm.
        dir_rows.push_back('{poll_of(0, 'h0002, 0, 0, 0, 2981, 0, 0, 0, 50, 0), 1'b0, no_want});
        dir_rows.push_back('{poll_of(0, 'h0008, 0, 0, 0, 3431, 0, 0, 0, 50, 0), 1'b0, no_want});
        dir_rows.push_back('{poll_of(0, 0, 0, 0, 0, 2981, 0, 0, 0, 50, 0), 1'b0, no_want});
        dir_rows.push_back('{poll_of(0, 0, 0, 'h0800, 1, 'hFFFF, 0, 0, 0, 50, 0), 1'b0, no_want});
        // Low battery: one notice, a second too soon, then charge above the limit.
        dir_rows.push_back('{poll_of(1, 0, 0, 0, 0, 2981, 0, 0, 0, 50, 0), 1'b0, no_want});
        dir_rows.push_back('{poll_of(0, 0, 0, 0, 0, 2981, 0, 0, 0, 5, 60001), 1'b0, no_want});
        dir_rows.push_back('{poll_of(0, 0, 0, 0, 0, 2981, 0, 0, 0, 5, 120001), 1'b0, no_want});
        dir_rows.push_back('{poll_of(0, 0, 0, 0, 0, 2981, 0, 0, 0, 127, 'hFFFFFFFF), 1'b0,
                             no_want});
        // Silent battery without AC while discharging: power off.
        dir_rows.push_back('{poll_of(1, 0, 1, 0, 0, 2981, 0, 0, 0, 50, 0), 1'b0, no_want});

        foreach (dir_rows[k]) begin
            send_poll(dir_rows[k].poll, dir_rows[k].typed, dir_rows[k].want);
        end

        // Random phases, each with its own registers and idling pattern.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_decisions();
            case (ph)
                0: begin
                    set_config(5, 40, 60, 70, 10, 32'd60000);
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    set_config(-40, 150, 150, 150, 100, 32'd0);
                    send_idle_pct = 86;
                    stall_pct     = 0;
                end
                2: begin
                    set_config(150, -40, -40, -40, 0, 32'hFFFF_FFFF);
                    send_idle_pct = 0;
                    stall_pct     = 86;
                end
                3, 4: begin
                    smin = int'($urandom_range(0, 80)) - 40;
                    set_config(smin, smin + 60, smin + 110,
                               int'($urandom_range(0, 190)) - 40,
                               int'($urandom_range(0, 100)), $urandom_range(0, 200000));
                    send_idle_pct = (ph == 3) ? 16 : 0;
                    stall_pct     = (ph == 3) ? 16 : 0;
                end
                default: begin
                    // Values outside the stated ranges are used as written.
                    set_config(-256, 255, 255, -256, 127, 32'd1);
                    send_idle_pct = 50;
                    stall_pct     = 50;
                end
            endcase
            clock_ms = $urandom;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 149) == 0) begin
                    drain_decisions();
                end
                gen_poll(p);
                send_poll(p, 1'b0, no_want);
            end
        end

        // Let the last decisions come back, then settle.
        i_in_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_decisions.size() != 0 && wait_cycles < END_WAIT_LIMIT) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (pending_decisions.size() != 0) begin
            report_mismatch($sformatf("%0d expected decisions never arrived",
                                      pending_decisions.size()));
        end
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
